>>> rtl/core/bic_pkg.sv
// Shared types, codes and register indexes for the button event classifier.
package bic_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned VAL_W      = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 40;

    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [VAL_W-1:0]      t_val;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Channel value codes.
    localparam t_val VAL_RELEASED = 3'd0;
    localparam t_val VAL_ACTIVE   = 3'd1;
    localparam t_val VAL_LONG     = 3'd2;
    localparam t_val VAL_DOUBLE   = 3'd3;
    localparam t_val VAL_SINGLE   = 3'd4;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_GPIO_BACKED   = 3'd0;
    localparam t_cfg_idx CFG_INVERT_INPUT  = 3'd1;
    localparam t_cfg_idx CFG_INPUT_MODE    = 3'd2;
    localparam t_cfg_idx CFG_DEBOUNCE_MS   = 3'd3;
    localparam t_cfg_idx CFG_LONG_PRESS_MS = 3'd4;
    localparam t_cfg_idx CFG_DOUBLE_CLK_MS = 3'd5;

    typedef enum logic [1:0] {
        MODE_MOMENTARY = 2'd0,
        MODE_TOGGLE    = 2'd1,
        MODE_LATCH     = 2'd2,
        MODE_CLICK     = 2'd3
    } t_mode;

    typedef struct packed {
        logic        gpio_backed;
        logic        invert_input;
        t_mode       input_mode;
        logic [7:0]  debounce_window_ms;
        logic [15:0] long_press_ms;
        logic [15:0] double_click_ms;
    } t_cfg;

    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [15:0] DOUBLE_CLK_RST = 16'd400;

endpackage

>>> rtl/core/bic_cfg_regs.sv
// Configuration register file for the button event classifier.
module bic_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  bic_pkg::t_cfg_idx  i_cfg_index,
    input  bic_pkg::t_cfg_data i_cfg_wdata,
    output bic_pkg::t_cfg      o_cfg
);
    import bic_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gpio_backed        <= 1'b1;
            r_cfg.invert_input       <= 1'b0;
            r_cfg.input_mode         <= MODE_MOMENTARY;
            r_cfg.debounce_window_ms <= 8'd0;
            r_cfg.long_press_ms      <= LONG_PRESS_RST;
            r_cfg.double_click_ms    <= DOUBLE_CLK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GPIO_BACKED:   r_cfg.gpio_backed        <= i_cfg_wdata[0];
                CFG_INVERT_INPUT:  r_cfg.invert_input       <= i_cfg_wdata[0];
                CFG_INPUT_MODE:    r_cfg.input_mode         <= t_mode'(i_cfg_wdata[1:0]);
                CFG_DEBOUNCE_MS:   r_cfg.debounce_window_ms <= i_cfg_wdata[7:0];
                CFG_LONG_PRESS_MS: r_cfg.long_press_ms      <= i_cfg_wdata;
                CFG_DOUBLE_CLK_MS: r_cfg.double_click_ms    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/bic_in_stage.sv
// Input register stage that holds one pin event until the classifier takes it.
module bic_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_raw_level,
    input  bic_pkg::t_time i_event_time_ms,
    output logic          o_valid,
    input  logic          i_take,
    output logic          o_raw_level,
    output bic_pkg::t_time o_event_time_ms
);
    import bic_pkg::*;

    logic  r_valid;
    logic  r_raw_level;
    t_time r_event_time_ms;
    logic  n_valid;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_raw_level     <= i_raw_level;
            r_event_time_ms <= i_event_time_ms;
        end
    end

    assign o_valid         = r_valid;
    assign o_raw_level     = r_raw_level;
    assign o_event_time_ms = r_event_time_ms;

endmodule

>>> rtl/core/bic_classify.sv
// Debounce, mode logic, channel state and result register for one button channel.
module bic_classify (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bic_pkg::t_cfg  i_cfg,
    input  logic          i_valid,
    output logic          o_take,
    input  logic          i_raw_level,
    input  bic_pkg::t_time i_event_time_ms,
    output logic          o_valid,
    input  logic          i_ready,
    output bic_pkg::t_val  o_channel_value,
    output bic_pkg::t_time o_change_time_ms
);
    import bic_pkg::*;

    logic  r_last_raw;
    t_time r_raw_change_time;
    logic  r_stable;
    t_val  r_value;
    t_time r_value_time;
    t_time r_press_start;
    t_time r_last_click;
    logic  r_out_valid;
    t_val  r_out_value;
    t_time r_out_time;

    logic  n_last_raw;
    t_time n_raw_change_time;
    logic  n_stable;
    t_val  n_value;
    t_time n_value_time;
    t_time n_press_start;
    t_time n_last_click;
    logic  n_out_valid;

    logic  emit;
    logic  lvl;
    t_time since_raw;
    t_time press_len;
    t_time click_gap;
    logic  bounce;

    // The stage advances whenever the result register is free or being drained.
    assign o_take = i_valid && (!r_out_valid || i_ready);

    always_comb begin
        n_last_raw        = r_last_raw;
        n_raw_change_time = r_raw_change_time;
        n_stable          = r_stable;
        n_value           = r_value;
        n_value_time      = r_value_time;
        n_press_start     = r_press_start;
        n_last_click      = r_last_click;
        emit              = 1'b0;

        lvl       = i_raw_level ^ i_cfg.invert_input;
        press_len = i_event_time_ms - r_press_start;
        click_gap = i_event_time_ms - r_last_click;

        if (lvl != r_last_raw) begin
            n_raw_change_time = i_event_time_ms;
        end
        since_raw = i_event_time_ms - n_raw_change_time;
        bounce    = (i_cfg.debounce_window_ms != 8'd0) &&
                    (since_raw < {24'd0, i_cfg.debounce_window_ms});

        if (!i_cfg.gpio_backed) begin
            // Passthrough leaves the debounce tracking untouched.
            n_raw_change_time = r_raw_change_time;
            n_value           = {2'b00, i_raw_level};
            n_value_time      = i_event_time_ms;
            emit              = 1'b1;
        end else begin
            n_last_raw = lvl;
            if (!bounce && (lvl != r_stable)) begin
                emit     = 1'b1;
                n_stable = lvl;
                case (i_cfg.input_mode)
                    MODE_MOMENTARY: begin
                        if (r_value != {2'b00, lvl}) begin
                            n_value      = {2'b00, lvl};
                            n_value_time = i_event_time_ms;
                        end
                    end
                    MODE_TOGGLE: begin
                        if (lvl) begin
                            n_value_time = i_event_time_ms;
                            if (r_value == VAL_RELEASED || r_value == VAL_ACTIVE) begin
                                n_value = r_value ^ VAL_ACTIVE;
                            end else begin
                                n_value = VAL_ACTIVE;
                            end
                        end
                    end
                    MODE_LATCH: begin
                        if (lvl) begin
                            n_value_time = i_event_time_ms;
                            n_value = (r_value == VAL_ACTIVE) ? VAL_RELEASED : VAL_ACTIVE;
                        end
                    end
                    default: begin
                        if (lvl) begin
                            n_press_start = i_event_time_ms;
                        end else begin
                            n_value_time = i_event_time_ms;
                            if (press_len >= {16'd0, i_cfg.long_press_ms}) begin
                                n_value = VAL_LONG;
                            end else begin
                                n_last_click = i_event_time_ms;
                                if (click_gap < {16'd0, i_cfg.double_click_ms}) begin
                                    n_value = VAL_DOUBLE;
                                end else begin
                                    n_value = VAL_SINGLE;
                                end
                            end
                        end
                    end
                endcase
            end
        end

        n_out_valid = r_out_valid;
        if (o_take && emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw        <= 1'b0;
            r_raw_change_time <= '0;
            r_stable          <= 1'b0;
            r_value           <= VAL_RELEASED;
            r_value_time      <= '0;
            r_press_start     <= '0;
            r_last_click      <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_last_raw        <= n_last_raw;
                r_raw_change_time <= n_raw_change_time;
                r_stable          <= n_stable;
                r_value           <= n_value;
                r_value_time      <= n_value_time;
                r_press_start     <= n_press_start;
                r_last_click      <= n_last_click;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_out_value <= n_value;
            r_out_time  <= n_value_time;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_channel_value  = r_out_value;
    assign o_change_time_ms = r_out_time;

endmodule

>>> rtl/core/button_input_event_classifier_unit.sv
// Top level of the debounced button event classifier.
// Each accepted pin event (a level and a millisecond timestamp) is debounced
// against the time of the last raw level change, then handled by the mode
// selected in input_mode; an event that gets through produces one result with
// the channel value and the time it last changed, while a bounced or
// unchanged event produces none. One event is accepted every clock cycle as
// long as the result side keeps up. An accepted event is held in the input
// register and then classified into the result register, which offers its
// result. A stalled result holds the classification stage, and the input
// register then fills and stalls the input.
// With gpio_backed cleared, every event passes straight to a result.
module button_input_event_classifier_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  bic_pkg::t_cfg_idx   i_cfg_index,
    input  bic_pkg::t_cfg_data  i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [0] raw_level, [32:1] event_time_ms, [39:33] zero
    input  logic [bic_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [2:0] channel_value, [34:3] change_time_ms, [39:35] zero
    output logic [bic_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bic_pkg::*;

    t_cfg  cfg;
    logic  in_valid;
    logic  in_take;
    logic  in_raw_level;
    t_time in_event_time;
    t_val  out_value;
    t_time out_time;

    bic_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bic_in_stage u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_raw_level     (s_axis_tdata[0]),
        .i_event_time_ms (s_axis_tdata[TIME_W:1]),
        .o_valid         (in_valid),
        .i_take          (in_take),
        .o_raw_level     (in_raw_level),
        .o_event_time_ms (in_event_time)
    );

    bic_classify u_cls (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (in_valid),
        .o_take           (in_take),
        .i_raw_level      (in_raw_level),
        .i_event_time_ms  (in_event_time),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_channel_value  (out_value),
        .o_change_time_ms (out_time)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - TIME_W - VAL_W){1'b0}}, out_time, out_value};

endmodule

>>> sim/button_input_event_classifier_unit_tb.sv
// Self-checking testbench for the button event classifier: directed table, then random phases.
module button_input_event_classifier_unit_tb;
    import bic_pkg::*;

    localparam int unsigned RANDOM_PHASES   = 20;
    localparam int unsigned ITEMS_PER_PHASE = 85;
    localparam int unsigned PAUSE_PHASE     = 2;
    localparam int unsigned HOLD_PHASE      = 3;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned SETTLE_CYCLES   = 6;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    // Index outside the register map; writes to it must be ignored.
    localparam t_cfg_idx    CFG_UNUSED_IDX  = 3'd7;

    typedef struct packed {
        t_val  value;
        t_time change_t;
    } channel_result_t;

    typedef struct {
        logic  last_raw;
        t_time raw_change_t;
        logic  stable;
        t_val  value;
        t_time value_t;
        t_time press_t;
        t_time click_t;
    } channel_state_t;

    typedef struct {
        bit        is_write;
        t_cfg_idx  reg_idx;
        t_cfg_data reg_data;
        logic      raw;
        t_time     stamp;
        bit        typed;
        bit        typed_emits;
        t_val      typed_val;
        t_time     typed_t;
    } stim_row_t;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    t_cfg_idx  i_cfg_index = '0;
    t_cfg_data i_cfg_wdata = '0;
    logic      s_axis_tvalid = 1'b0;
    logic      s_axis_tready;
    // [0] raw_level, [32:1] event_time_ms, [39:33] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic      m_axis_tvalid;
    logic      m_axis_tready = 1'b0;
    // [2:0] channel_value, [34:3] change_time_ms, [39:35] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_cfg            cfg;
    channel_state_t  chan;
    channel_result_t pending_results[$];
    channel_result_t oldest;
    stim_row_t       stim_table[$];
    int unsigned     error_count = 0;
    int unsigned     idle_cycles = 0;
    bit              tx_eager = 1'b0;
    bit              rx_eager = 1'b0;
    bit              rx_hold  = 1'b0;

    button_input_event_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic void set_value(input t_val v, input t_time stamp);
        chan.value   = v;
        chan.value_t = stamp;
    endfunction

    function automatic void apply_register(input t_cfg_idx idx, input t_cfg_data data);
        case (idx)
            CFG_GPIO_BACKED:   cfg.gpio_backed        = data[0];
            CFG_INVERT_INPUT:  cfg.invert_input       = data[0];
            CFG_INPUT_MODE:    cfg.input_mode         = t_mode'(data[1:0]);
            CFG_DEBOUNCE_MS:   cfg.debounce_window_ms = data[7:0];
            CFG_LONG_PRESS_MS: cfg.long_press_ms      = data;
            CFG_DOUBLE_CLK_MS: cfg.double_click_ms    = data;
            default: ;
        endcase
    endfunction

    // Advances the channel state by one pin event; returns 1 when a result is due.
    function automatic bit classify_event(input logic raw, input t_time stamp);
        logic  lvl;
        t_time since;
        if (!cfg.gpio_backed) begin
            set_value({2'b00, raw}, stamp);
            return 1'b1;
        end
        lvl = raw ^ cfg.invert_input;
        if (lvl != chan.last_raw) begin
            chan.last_raw     = lvl;
            chan.raw_change_t = stamp;
        end
        since = stamp - chan.raw_change_t;
        if (cfg.debounce_window_ms != 8'd0 && since < {24'd0, cfg.debounce_window_ms})
            return 1'b0;
        if (lvl == chan.stable)
            return 1'b0;
        chan.stable = lvl;
        case (cfg.input_mode)
            MODE_MOMENTARY: begin
                if (chan.value != {2'b00, lvl})
                    set_value({2'b00, lvl}, stamp);
            end
            MODE_TOGGLE: begin
                // A leftover click code goes straight to active on a press.
                if (lvl)
                    set_value((chan.value <= VAL_ACTIVE) ? (chan.value ^ VAL_ACTIVE)
                                                         : VAL_ACTIVE, stamp);
            end
            MODE_LATCH: begin
                if (lvl)
                    set_value((chan.value == VAL_ACTIVE) ? VAL_RELEASED : VAL_ACTIVE, stamp);
            end
            default: begin
                if (lvl) begin
                    chan.press_t = stamp;
                end else begin
                    since = stamp - chan.press_t;
                    if (since >= {16'd0, cfg.long_press_ms}) begin
                        set_value(VAL_LONG, stamp);
                    end else begin
                        since = stamp - chan.click_t;
                        set_value((since < {16'd0, cfg.double_click_ms}) ? VAL_DOUBLE
                                                                        : VAL_SINGLE, stamp);
                        chan.click_t = stamp;
                    end
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic stim_row_t row_write(input t_cfg_idx idx, input t_cfg_data data);
        stim_row_t r;
        r = '{1'b1, idx, data, 1'b0, '0, 1'b0, 1'b0, VAL_RELEASED, '0};
        return r;
    endfunction

    function automatic stim_row_t row_event(input logic raw, input t_time stamp);
        stim_row_t r;
        r = '{1'b0, CFG_GPIO_BACKED, '0, raw, stamp, 1'b0, 1'b0, VAL_RELEASED, '0};
        return r;
    endfunction

    function automatic stim_row_t row_known(input logic raw, input t_time stamp,
                                            input bit emits, input t_val v, input t_time t);
        stim_row_t r;
        r = '{1'b0, CFG_GPIO_BACKED, '0, raw, stamp, 1'b1, emits, v, t};
        return r;
    endfunction

    // Fills the unused upper bits of a narrow register with noise.
    function automatic t_cfg_data with_spare_bits(input t_cfg_data v, input int unsigned w);
        t_cfg_data junk;
        junk = t_cfg_data'($urandom) << w;
        return junk | v;
    endfunction

    function automatic t_cfg_data pick_threshold();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return t_cfg_data'($urandom_range(1, 300));
            default: return t_cfg_data'($urandom);
        endcase
    endfunction

    // Mostly steps that land near the debounce, long-press and double-click limits.
    function automatic t_time next_stamp(input t_time now);
        int unsigned pick;
        int unsigned reach;
        pick = $urandom_range(0, 15);
        if (pick < 6)
            return now + $urandom_range(0, 2 * int'(cfg.debounce_window_ms) + 3);
        if (pick < 11) begin
            reach = $urandom_range(0, 1) ? int'(cfg.long_press_ms) : int'(cfg.double_click_ms);
            return now + $urandom_range(0, reach + reach / 4 + 20);
        end
        if (pick < 14)
            return now + $urandom_range(0, 50);
        if (pick == 14)
            return $urandom;
        return now - $urandom_range(1, 300);
    endfunction

    task automatic write_register(input t_cfg_idx idx, input t_cfg_data data);
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        apply_register(idx, data);
        @(posedge i_clk);
    endtask

    // Stops offering events and waits until every result is in and the pipeline is empty.
    task automatic drain_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic play_event(input logic raw, input t_time stamp, output bit emits);
        int unsigned gap;
        gap = tx_eager ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {7'd0, stamp, raw};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        emits = classify_event(raw, stamp);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with none expected: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_axis_tdata[2:0] !== oldest.value) begin
                    $error("channel_value: expected %0d, got %0d", oldest.value,
                           m_axis_tdata[2:0]);
                    error_count++;
                end
                if (m_axis_tdata[34:3] !== oldest.change_t) begin
                    $error("change_time_ms: expected %h, got %h", oldest.change_t,
                           m_axis_tdata[34:3]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request.
    initial begin : receiver_proc
        int unsigned stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end else begin
                stall = rx_eager ? 0 : $urandom_range(0, 15);
                if (stall != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin : main_proc
        bit    emits;
        logic  level;
        t_time stamp;
        cfg  = '{1'b1, 1'b0, MODE_MOMENTARY, 8'd0, LONG_PRESS_RST, DOUBLE_CLK_RST};
        chan = '{1'b0, '0, 1'b0, VAL_RELEASED, '0, '0, '0};

        // Momentary mode at reset settings.
        stim_table.push_back(row_known(1'b0, 32'd5, 1'b0, VAL_RELEASED, '0));
        stim_table.push_back(row_known(1'b1, 32'd10, 1'b1, VAL_ACTIVE, 32'd10));
        stim_table.push_back(row_known(1'b0, 32'hFFFF_FFFF, 1'b1, VAL_RELEASED, 32'hFFFF_FFFF));
        stim_table.push_back(row_write(CFG_INVERT_INPUT, 16'd1));
        stim_table.push_back(row_known(1'b0, 32'd0, 1'b1, VAL_ACTIVE, 32'd0));
        stim_table.push_back(row_write(CFG_INVERT_INPUT, 16'd0));
        stim_table.push_back(row_known(1'b1, 32'd100, 1'b0, VAL_RELEASED, '0));
        // Toggle: a release still reports the unchanged value.
        stim_table.push_back(row_write(CFG_INPUT_MODE, {14'd0, MODE_TOGGLE}));
        stim_table.push_back(row_known(1'b0, 32'd200, 1'b1, VAL_ACTIVE, 32'd0));
        stim_table.push_back(row_event(1'b1, 32'd300));
        stim_table.push_back(row_write(CFG_INPUT_MODE, {14'd0, MODE_LATCH}));
        stim_table.push_back(row_event(1'b0, 32'd400));
        stim_table.push_back(row_event(1'b1, 32'd500));
        // Click classification: single, double, long.
        stim_table.push_back(row_write(CFG_INPUT_MODE, {14'd0, MODE_CLICK}));
        stim_table.push_back(row_event(1'b0, 32'd600));
        stim_table.push_back(row_event(1'b1, 32'd700));
        stim_table.push_back(row_event(1'b0, 32'd800));
        stim_table.push_back(row_event(1'b1, 32'd900));
        stim_table.push_back(row_event(1'b0, 32'd5000));
        // Toggle starting from a click code.
        stim_table.push_back(row_write(CFG_INPUT_MODE, {14'd0, MODE_TOGGLE}));
        stim_table.push_back(row_event(1'b1, 32'd5100));
        // Widest debounce window: a raw change and the last bounced tick are dropped.
        stim_table.push_back(row_write(CFG_DEBOUNCE_MS, 16'd255));
        stim_table.push_back(row_known(1'b0, 32'd6000, 1'b0, VAL_RELEASED, '0));
        stim_table.push_back(row_known(1'b0, 32'd6254, 1'b0, VAL_RELEASED, '0));
        stim_table.push_back(row_event(1'b0, 32'd6255));
        // Zero long-press limit, widest double-click gap.
        stim_table.push_back(row_write(CFG_DEBOUNCE_MS, 16'd0));
        stim_table.push_back(row_write(CFG_LONG_PRESS_MS, 16'd0));
        stim_table.push_back(row_write(CFG_DOUBLE_CLK_MS, 16'hFFFF));
        stim_table.push_back(row_write(CFG_INPUT_MODE, {14'd0, MODE_CLICK}));
        stim_table.push_back(row_event(1'b1, 32'd7000));
        stim_table.push_back(row_event(1'b0, 32'd7000));
        stim_table.push_back(row_write(CFG_LONG_PRESS_MS, 16'hFFFF));
        stim_table.push_back(row_event(1'b1, 32'd7001));
        stim_table.push_back(row_event(1'b0, 32'd7002));
        stim_table.push_back(row_write(CFG_UNUSED_IDX, 16'hFFFF));
        // Passthrough ignores inversion and reports every event.
        stim_table.push_back(row_write(CFG_GPIO_BACKED, 16'd0));
        stim_table.push_back(row_write(CFG_INVERT_INPUT, 16'd1));
        stim_table.push_back(row_known(1'b1, 32'h8000_0000, 1'b1, VAL_ACTIVE, 32'h8000_0000));
        stim_table.push_back(row_known(1'b1, 32'h8000_0000, 1'b1, VAL_ACTIVE, 32'h8000_0000));
        stim_table.push_back(row_known(1'b0, 32'd1, 1'b1, VAL_RELEASED, 32'd1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i]) begin
            if (stim_table[i].is_write) begin
                drain_idle();
                write_register(stim_table[i].reg_idx, stim_table[i].reg_data);
            end else begin
                play_event(stim_table[i].raw, stim_table[i].stamp, emits);
                if (!stim_table[i].typed) begin
                    if (emits)
                        pending_results.push_back('{chan.value, chan.value_t});
                end else if (stim_table[i].typed_emits) begin
                    pending_results.push_back('{stim_table[i].typed_val,
                                                stim_table[i].typed_t});
                end
            end
        end

        level = 1'b0;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_idle();
            write_register(CFG_GPIO_BACKED,
                           with_spare_bits(t_cfg_data'($urandom_range(0, 5) != 0), 1));
            write_register(CFG_INVERT_INPUT,
                           with_spare_bits(t_cfg_data'($urandom_range(0, 1)), 1));
            write_register(CFG_INPUT_MODE,
                           with_spare_bits(t_cfg_data'($urandom_range(0, 3)), 2));
            case ($urandom_range(0, 3))
                0:       write_register(CFG_DEBOUNCE_MS, with_spare_bits(16'd0, 8));
                1:       write_register(CFG_DEBOUNCE_MS, with_spare_bits(16'd255, 8));
                2:       write_register(CFG_DEBOUNCE_MS,
                                        with_spare_bits(t_cfg_data'($urandom_range(1, 40)), 8));
                default: write_register(CFG_DEBOUNCE_MS,
                                        with_spare_bits(t_cfg_data'($urandom_range(0, 255)), 8));
            endcase
            write_register(CFG_LONG_PRESS_MS, pick_threshold());
            write_register(CFG_DOUBLE_CLK_MS, pick_threshold());
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_UNUSED_IDX, t_cfg_data'($urandom));

            tx_eager = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            if (phase == HOLD_PHASE)
                rx_hold = 1'b1;
            // Some phases start just below the timestamp wrap.
            stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000)
                                                : $urandom;

            for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
                    drain_idle();
                if ($urandom_range(0, 3) != 0)
                    level = ~level;
                stamp = next_stamp(stamp);
                play_event(level, stamp, emits);
                if (emits)
                    pending_results.push_back('{chan.value, chan.value_t});
            end
        end

        drain_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
